[hdl/smac_pkg.sv]
// ----------------------------------------------------------------------------
// SMA crossover package
// Field widths, relation and signal codes, register indexes and the control
// struct shared by the crossover pipeline stages.
// ----------------------------------------------------------------------------
package smac_pkg;

    localparam int PRICE_W      = 32;
    localparam int INDEX_W      = 32;
    localparam int SIGNAL_W     = 2;
    localparam int WINDOW_REG_W = 7;
    localparam int CFG_INDEX_W  = 8;
    localparam int CFG_DATA_W   = 32;

    localparam logic [WINDOW_REG_W-1:0] SHORT_WINDOW_RESET = WINDOW_REG_W'(5);
    localparam logic [WINDOW_REG_W-1:0] LONG_WINDOW_RESET  = WINDOW_REG_W'(10);

    localparam logic [CFG_INDEX_W-1:0] REG_SHORT_WINDOW = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_LONG_WINDOW  = CFG_INDEX_W'(1);

    // Relation of the short average to the long average.
    localparam logic [1:0] REL_EQUAL = 2'd0;
    localparam logic [1:0] REL_ABOVE = 2'd1;
    localparam logic [1:0] REL_BELOW = 2'd2;

    localparam logic [SIGNAL_W-1:0] SIG_NONE = SIGNAL_W'(0);
    localparam logic [SIGNAL_W-1:0] SIG_BUY  = SIGNAL_W'(1);
    localparam logic [SIGNAL_W-1:0] SIG_SELL = SIGNAL_W'(2);

    typedef struct packed {
        logic valid;
        logic armed;
    } smac_ctl_t;

endpackage

[hdl/smac_price_if.sv]
// ----------------------------------------------------------------------------
// Price request channel
// Valid/ready channel that carries one price sample per request.
// ----------------------------------------------------------------------------
interface smac_price_if import smac_pkg::*; ();

    logic               valid;
    logic               ready;
    logic [PRICE_W-1:0] price;

    modport source (output valid, output price, input ready);
    modport sink   (input valid, input price, output ready);

endinterface

[hdl/smac_result_if.sv]
// ----------------------------------------------------------------------------
// Result request channel
// Valid/ready channel that carries the crossover code and the sample index.
// ----------------------------------------------------------------------------
interface smac_result_if import smac_pkg::*; ();

    logic                valid;
    logic                ready;
    logic [SIGNAL_W-1:0] signal;
    logic [INDEX_W-1:0]  sample_index;

    modport source (output valid, output signal, output sample_index, input ready);
    modport sink   (input valid, input signal, input sample_index, output ready);

endinterface

[hdl/smac_cfg_if.sv]
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel that carries a register index and write data.
// ----------------------------------------------------------------------------
interface smac_cfg_if import smac_pkg::*; ();

    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);

endinterface

[hdl/smac_front.sv]
// ----------------------------------------------------------------------------
// SMA crossover front end
// Accepts prices, writes them to the price ring and fetches the two prices
// that leave the short and long windows, along with the sample index.
// ----------------------------------------------------------------------------
module smac_front import smac_pkg::*; #(
    parameter int MAX_WINDOW = 64,
    parameter int PRICE_BITS = 32,
    localparam int P_W   = (PRICE_BITS < PRICE_W) ? PRICE_BITS : PRICE_W,
    localparam int AW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1,
    localparam int WIN_W = $clog2(MAX_WINDOW + 1),
    localparam int WU_W  = $clog2(MAX_WINDOW + 2)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               clear,
    input  logic [WIN_W-1:0]   ws,
    input  logic [WIN_W-1:0]   wl,
    smac_price_if.sink         sample,
    input  logic               take,
    output smac_ctl_t          ctl,
    output logic [P_W-1:0]     price_q,
    output logic [P_W-1:0]     old_s,
    output logic [P_W-1:0]     old_l,
    output logic [INDEX_W-1:0] index_q
);

    logic [P_W-1:0]     ring [MAX_WINDOW];

    logic [AW-1:0]      ptr_reg;
    logic [AW-1:0]      ptr_next;
    logic [WU_W-1:0]    warmup_reg;
    logic [WU_W-1:0]    warmup_next;
    logic [INDEX_W-1:0] index_reg;
    logic [INDEX_W-1:0] index_next;
    logic               valid_reg;

    logic               armed_reg;
    logic               ok_s_reg;
    logic               ok_l_reg;
    logic [P_W-1:0]     price_reg;
    logic [P_W-1:0]     rd_s_reg;
    logic [P_W-1:0]     rd_l_reg;
    logic [INDEX_W-1:0] idx_q_reg;

    logic               acc;
    logic [P_W-1:0]     price_m;
    logic [AW-1:0]      addr_s;
    logic [AW-1:0]      addr_l;
    logic               ok_s;
    logic               ok_l;
    logic [WIN_W-1:0]   start;
    logic               armed;

    // Ring slot that held the price w samples back.
    function automatic logic [AW-1:0] back_addr(input logic [AW-1:0] p,
                                                input logic [WIN_W-1:0] w);
        logic [AW:0] pe;
        logic [AW:0] we;
        pe = {1'b0, p};
        we = (AW + 1)'(w);
        if (pe >= we)
        begin
            return AW'(pe - we);
        end
        return AW'(pe + (AW + 1)'(MAX_WINDOW) - we);
    endfunction

    assign sample.ready = !valid_reg || take;
    assign acc          = sample.valid && sample.ready;
    assign price_m      = sample.price[P_W-1:0];

    assign addr_s = back_addr(ptr_reg, ws);
    assign addr_l = back_addr(ptr_reg, wl);

    // Slots are filled in order from zero after a clear, so the fill count
    // tells whether a slot has been written since the clear; unwritten slots read as zero.
    assign ok_s = (warmup_reg >= WU_W'(MAX_WINDOW)) || (WU_W'(addr_s) < warmup_reg);
    assign ok_l = (warmup_reg >= WU_W'(MAX_WINDOW)) || (WU_W'(addr_l) < warmup_reg);

    assign start = (ws > wl) ? ws : wl;
    assign armed = warmup_reg >= WU_W'(start);

    assign ptr_next    = (ptr_reg == AW'(MAX_WINDOW - 1)) ? '0 : ptr_reg + AW'(1);
    assign warmup_next = (warmup_reg < WU_W'(MAX_WINDOW + 1)) ? warmup_reg + WU_W'(1)
                                                              : warmup_reg;
    assign index_next  = index_reg + INDEX_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg    <= '0;
            warmup_reg <= '0;
            index_reg  <= '0;
            valid_reg  <= 1'b0;
        end
        else if (clear)
        begin
            ptr_reg    <= '0;
            warmup_reg <= '0;
            index_reg  <= '0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            if (acc)
            begin
                ptr_reg    <= ptr_next;
                warmup_reg <= warmup_next;
                index_reg  <= index_next;
            end
            if (sample.ready)
            begin
                valid_reg <= acc;
            end
        end
    end

    // Read-first ring: at the full window the read slot is the one being
    // overwritten, and the old price is the one wanted.
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            ring[ptr_reg] <= price_m;
            rd_s_reg      <= ring[addr_s];
            rd_l_reg      <= ring[addr_l];
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            price_reg <= price_m;
            idx_q_reg <= index_reg;
            armed_reg <= armed;
            ok_s_reg  <= ok_s;
            ok_l_reg  <= ok_l;
        end
    end

    assign ctl     = '{valid: valid_reg, armed: armed_reg};
    assign price_q = price_reg;
    assign old_s   = ok_s_reg ? rd_s_reg : '0;
    assign old_l   = ok_l_reg ? rd_l_reg : '0;
    assign index_q = idx_q_reg;

    a_warmup_bound: assert property (@(posedge clk) disable iff (!rst_n)
        warmup_reg <= WU_W'(MAX_WINDOW + 1))
        else $error("warmup count passed its saturation value");

    a_ptr_tracks_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (warmup_reg < WU_W'(MAX_WINDOW)) |-> (WU_W'(ptr_reg) == warmup_reg))
        else $error("ring pointer disagrees with fill count during warmup");

endmodule

[hdl/smac_sum.sv]
// ----------------------------------------------------------------------------
// SMA crossover window sums
// Keeps the running short and long window sums, one update per sample.
// ----------------------------------------------------------------------------
module smac_sum import smac_pkg::*; #(
    parameter int MAX_WINDOW = 64,
    parameter int PRICE_BITS = 32,
    localparam int P_W   = (PRICE_BITS < PRICE_W) ? PRICE_BITS : PRICE_W,
    localparam int SUM_W = P_W + ((MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               clear,
    input  smac_ctl_t          in_ctl,
    input  logic [P_W-1:0]     price,
    input  logic [P_W-1:0]     old_s,
    input  logic [P_W-1:0]     old_l,
    input  logic [INDEX_W-1:0] index_in,
    input  logic               take,
    output logic               advance,
    output smac_ctl_t          ctl,
    output logic [SUM_W-1:0]   short_sum,
    output logic [SUM_W-1:0]   long_sum,
    output logic [INDEX_W-1:0] index_q
);

    logic               valid_reg;
    logic               armed_reg;
    logic [SUM_W-1:0]   short_sum_reg;
    logic [SUM_W-1:0]   short_sum_next;
    logic [SUM_W-1:0]   long_sum_reg;
    logic [SUM_W-1:0]   long_sum_next;
    logic [INDEX_W-1:0] index_reg;
    logic               update;

    assign advance = !valid_reg || take;
    assign update  = in_ctl.valid && advance;

    // The true sums never go negative and fit the width, so modular
    // arithmetic gives them exactly.
    assign short_sum_next = short_sum_reg + SUM_W'(price) - SUM_W'(old_s);
    assign long_sum_next  = long_sum_reg + SUM_W'(price) - SUM_W'(old_l);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            short_sum_reg <= '0;
            long_sum_reg  <= '0;
        end
        else if (clear)
        begin
            valid_reg     <= 1'b0;
            short_sum_reg <= '0;
            long_sum_reg  <= '0;
        end
        else
        begin
            if (advance)
            begin
                valid_reg <= in_ctl.valid;
            end
            if (update)
            begin
                short_sum_reg <= short_sum_next;
                long_sum_reg  <= long_sum_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (update)
        begin
            armed_reg <= in_ctl.armed;
            index_reg <= index_in;
        end
    end

    assign ctl       = '{valid: valid_reg, armed: armed_reg};
    assign short_sum = short_sum_reg;
    assign long_sum  = long_sum_reg;
    assign index_q   = index_reg;

endmodule

[hdl/smac_cmp.sv]
// ----------------------------------------------------------------------------
// SMA crossover compare and result stage
// Cross-multiplies the window sums, tracks the previous relation and holds
// the result until the receiver takes it.
// ----------------------------------------------------------------------------
module smac_cmp import smac_pkg::*; #(
    parameter int MAX_WINDOW = 64,
    parameter int PRICE_BITS = 32,
    localparam int P_W    = (PRICE_BITS < PRICE_W) ? PRICE_BITS : PRICE_W,
    localparam int SUM_W  = P_W + ((MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1),
    localparam int WIN_W  = $clog2(MAX_WINDOW + 1),
    localparam int PROD_W = SUM_W + WIN_W
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               clear,
    input  smac_ctl_t          in_ctl,
    input  logic [SUM_W-1:0]   short_sum,
    input  logic [SUM_W-1:0]   long_sum,
    input  logic [INDEX_W-1:0] index_in,
    input  logic [WIN_W-1:0]   ws,
    input  logic [WIN_W-1:0]   wl,
    output logic               take,
    smac_result_if.source      result
);

    logic                valid_reg;
    logic [1:0]          prev_rel_reg;
    logic [SIGNAL_W-1:0] signal_reg;
    logic [SIGNAL_W-1:0] signal_next;
    logic [INDEX_W-1:0]  index_reg;
    logic [PROD_W-1:0]   prod_s;
    logic [PROD_W-1:0]   prod_l;
    logic [1:0]          rel;
    logic                update;

    assign take   = !valid_reg || result.ready;
    assign update = in_ctl.valid && take;

    // short/ws against long/wl, compared without division.
    assign prod_s = PROD_W'(short_sum) * PROD_W'(wl);
    assign prod_l = PROD_W'(long_sum) * PROD_W'(ws);

    always_comb
    begin
        if (prod_s > prod_l)
        begin
            rel = REL_ABOVE;
        end
        else if (prod_s < prod_l)
        begin
            rel = REL_BELOW;
        end
        else
        begin
            rel = REL_EQUAL;
        end
    end

    always_comb
    begin
        signal_next = SIG_NONE;
        if (in_ctl.armed && rel == REL_ABOVE && prev_rel_reg != REL_ABOVE)
        begin
            signal_next = SIG_BUY;
        end
        else if (in_ctl.armed && rel == REL_BELOW && prev_rel_reg != REL_BELOW)
        begin
            signal_next = SIG_SELL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= 1'b0;
            prev_rel_reg <= REL_EQUAL;
        end
        else if (clear)
        begin
            valid_reg    <= 1'b0;
            prev_rel_reg <= REL_EQUAL;
        end
        else
        begin
            if (take)
            begin
                valid_reg <= in_ctl.valid;
            end
            if (update)
            begin
                prev_rel_reg <= rel;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (update)
        begin
            signal_reg <= signal_next;
            index_reg  <= index_in;
        end
    end

    assign result.valid        = valid_reg;
    assign result.signal       = signal_reg;
    assign result.sample_index = index_reg;

    a_buy_after_above: assert property (@(posedge clk) disable iff (!rst_n)
        (update && !clear) |=> (signal_reg != SIG_BUY || prev_rel_reg == REL_ABOVE))
        else $error("buy reported without the short average above the long one");

    a_sell_after_below: assert property (@(posedge clk) disable iff (!rst_n)
        (update && !clear) |=> (signal_reg != SIG_SELL || prev_rel_reg == REL_BELOW))
        else $error("sell reported without the short average below the long one");

    a_equal_windows_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (update && !clear && ws == wl) |=> (signal_reg == SIG_NONE))
        else $error("crossover reported with equal windows");

endmodule

[hdl/sma_crossover_signal_core.sv]
// ----------------------------------------------------------------------------
// SMA crossover signal core
// Moving average crossover detector on a stream of integer price ticks.
//
// Channels: sample carries one price per request; result carries the
// crossover code (none, buy, sell) and the sample index for every sample, in
// order. cfg writes the short window (index 0) or long window (index 1);
// any such write restarts the stream at sample index 0 with empty windows.
// cfg is always ready. The user must see that cfg is written only while the
// block is idle; the block itself does not enforce this. A sample passes
// the ring read, window sum update, and compare and result register stages,
// each of them registered, before its result is valid.
// Throughput: one sample per cycle while results are taken; the ring has
// one write and two reads per cycle, and the sum update feeds its register.
// Reset: windows return to 5 and 10, the stream restarts at index 0. The
// ring needs no clearing pass; its fill count masks slots not yet written.
// When the receiver stalls, the result holds, the two stages before it
// fill, and then sample.ready drops until the result is taken.
// ----------------------------------------------------------------------------
module sma_crossover_signal_core import smac_pkg::*; #(
    parameter int MAX_WINDOW = 64,
    parameter int PRICE_BITS = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    smac_price_if.sink    sample,
    smac_result_if.source result,
    smac_cfg_if.sink      cfg
);

    localparam int P_W   = (PRICE_BITS < PRICE_W) ? PRICE_BITS : PRICE_W;
    localparam int SUM_W = P_W + ((MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1);
    localparam int WIN_W = $clog2(MAX_WINDOW + 1);
    localparam int CW    = (WIN_W > WINDOW_REG_W) ? WIN_W : WINDOW_REG_W;

    logic [WINDOW_REG_W-1:0] short_window_reg;
    logic [WINDOW_REG_W-1:0] long_window_reg;
    logic                    cfg_wr;
    logic                    clear;
    logic [WIN_W-1:0]        ws;
    logic [WIN_W-1:0]        wl;

    smac_ctl_t               ctl1;
    logic [P_W-1:0]          price1;
    logic [P_W-1:0]          old_s1;
    logic [P_W-1:0]          old_l1;
    logic [INDEX_W-1:0]      index1;
    logic                    advance1;

    smac_ctl_t               ctl2;
    logic [SUM_W-1:0]        short_sum2;
    logic [SUM_W-1:0]        long_sum2;
    logic [INDEX_W-1:0]      index2;
    logic                    take2;

    // Zero acts as one, anything above the ring depth as the ring depth.
    function automatic logic [WIN_W-1:0] eff_window(input logic [WINDOW_REG_W-1:0] w);
        if (w == '0)
        begin
            return WIN_W'(1);
        end
        if (CW'(w) > CW'(MAX_WINDOW))
        begin
            return WIN_W'(MAX_WINDOW);
        end
        return WIN_W'(w);
    endfunction

    assign cfg.ready = 1'b1;
    assign cfg_wr    = cfg.valid && cfg.ready;
    assign clear     = cfg_wr && (cfg.index == REG_SHORT_WINDOW ||
                                  cfg.index == REG_LONG_WINDOW);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_window_reg <= SHORT_WINDOW_RESET;
            long_window_reg  <= LONG_WINDOW_RESET;
        end
        else if (cfg_wr)
        begin
            if (cfg.index == REG_SHORT_WINDOW)
            begin
                short_window_reg <= cfg.data[WINDOW_REG_W-1:0];
            end
            if (cfg.index == REG_LONG_WINDOW)
            begin
                long_window_reg <= cfg.data[WINDOW_REG_W-1:0];
            end
        end
    end

    assign ws = eff_window(short_window_reg);
    assign wl = eff_window(long_window_reg);

    smac_front #(
        .MAX_WINDOW (MAX_WINDOW),
        .PRICE_BITS (PRICE_BITS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (clear),
        .ws      (ws),
        .wl      (wl),
        .sample  (sample),
        .take    (advance1),
        .ctl     (ctl1),
        .price_q (price1),
        .old_s   (old_s1),
        .old_l   (old_l1),
        .index_q (index1)
    );

    smac_sum #(
        .MAX_WINDOW (MAX_WINDOW),
        .PRICE_BITS (PRICE_BITS)
    ) u_sum (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (clear),
        .in_ctl    (ctl1),
        .price     (price1),
        .old_s     (old_s1),
        .old_l     (old_l1),
        .index_in  (index1),
        .take      (take2),
        .advance   (advance1),
        .ctl       (ctl2),
        .short_sum (short_sum2),
        .long_sum  (long_sum2),
        .index_q   (index2)
    );

    smac_cmp #(
        .MAX_WINDOW (MAX_WINDOW),
        .PRICE_BITS (PRICE_BITS)
    ) u_cmp (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (clear),
        .in_ctl    (ctl2),
        .short_sum (short_sum2),
        .long_sum  (long_sum2),
        .index_in  (index2),
        .ws        (ws),
        .wl        (wl),
        .take      (take2),
        .result    (result)
    );

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !sample.ready |-> (result.valid && !result.ready))
        else $error("sample channel stalled while the result side can move");

endmodule
